@@ sv/fsp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fsp_pkg;

    localparam int MAX_FRAMES = 64;
    localparam int IDX_W      = $clog2(MAX_FRAMES);
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
    localparam int TIME_W     = 16;
    localparam int SPRITE_W   = 16;
    localparam int SPD_W      = 12;
    localparam int PROD_W     = TIME_W + SPD_W;
    localparam int TIMER_W    = 32;
    localparam int FRAC_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SPD_W;

    localparam logic [SPD_W-1:0] SPEED_RESET = SPD_W'(256);

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_PLAY   = 3'd1;
    localparam logic [2:0] OP_PAUSE  = 3'd2;
    localparam logic [2:0] OP_STOP   = 3'd3;
    localparam logic [2:0] OP_REWIND = 3'd4;
    localparam logic [2:0] OP_APPEND = 3'd5;
    localparam logic [2:0] OP_CLEAR  = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_LOOP  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED = CFG_IDX_W'(1);

    typedef struct packed {
        logic                we;
        logic [IDX_W-1:0]    waddr;
        logic [SPRITE_W-1:0] wsprite;
        logic [TIME_W-1:0]   wdur;
        logic [IDX_W-1:0]    raddr;
    } tbl_req_t;

    typedef struct packed {
        logic [SPRITE_W-1:0] sprite;
        logic [TIME_W-1:0]   dur;
    } tbl_rsp_t;

endpackage

`default_nettype wire

@@ sv/fsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface fsp_req_if import fsp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [2:0]          operation;
    logic [TIME_W-1:0]   delta_time;
    logic [SPRITE_W-1:0] new_sprite_id;
    logic [TIME_W-1:0]   new_duration;

    modport source (output valid, operation, delta_time, new_sprite_id, new_duration,
                    input ready);
    modport sink   (input valid, operation, delta_time, new_sprite_id, new_duration,
                    output ready);
endinterface

interface fsp_rsp_if import fsp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [IDX_W-1:0]    frame_index;
    logic [SPRITE_W-1:0] current_sprite;
    logic                sprite_valid;
    logic                is_playing;
    logic                is_finished;

    modport source (output valid, frame_index, current_sprite, sprite_valid, is_playing,
                    is_finished, input ready);
    modport sink   (input valid, frame_index, current_sprite, sprite_valid, is_playing,
                    is_finished, output ready);
endinterface

`default_nettype wire

@@ sv/fsp_table.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fsp_table import fsp_pkg::*; (
    input  wire logic     clk,
    input  wire tbl_req_t req,
    output tbl_rsp_t      rsp
);

    logic [SPRITE_W+TIME_W-1:0] mem_reg [MAX_FRAMES];
    logic [SPRITE_W+TIME_W-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem_reg[req.waddr] <= {req.wsprite, req.wdur};
        end
        rd_reg <= mem_reg[req.raddr];
    end

    assign rsp.sprite = rd_reg[SPRITE_W+TIME_W-1:TIME_W];
    assign rsp.dur    = rd_reg[TIME_W-1:0];

endmodule

`default_nettype wire

@@ sv/fsp_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fsp_core import fsp_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             loop_enable,
    input  wire logic [SPD_W-1:0] play_speed,
    fsp_req_if.sink               req,
    fsp_rsp_if.source             rsp,
    output tbl_req_t              tbl_req,
    input  wire tbl_rsp_t         tbl_rsp
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_SUM   = 6'b000100,
        S_FETCH = 6'b001000,
        S_STEP  = 6'b010000,
        S_RESP  = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [2:0]          op_reg, op_next;
    logic [TIME_W-1:0]   delta_reg, delta_next;
    logic [SPRITE_W-1:0] spr_reg, spr_next;
    logic [TIME_W-1:0]   dur_reg, dur_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [TIMER_W-1:0]  t_reg, t_next;
    logic [TIMER_W-1:0]  timer_reg, timer_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    loaded_reg, loaded_next;
    logic                playing_reg, playing_next;
    logic                finished_reg, finished_next;
    logic                run_reg, run_next;
    logic                ovalid_reg, ovalid_next;
    logic [IDX_W-1:0]    oidx_reg, oidx_next;
    logic [SPRITE_W-1:0] ospr_reg, ospr_next;
    logic                osv_reg, osv_next;
    logic                oplay_reg, oplay_next;
    logic                ofin_reg, ofin_next;

    logic [TIMER_W:0]    sum;
    logic [TIMER_W-1:0]  need;
    logic [CNT_W-1:0]    idx_ext;
    logic [CNT_W-1:0]    idx_inc;

    assign sum     = {1'b0, timer_reg} + (TIMER_W+1)'(prod_reg);
    assign need    = TIMER_W'({tbl_rsp.dur, {FRAC_W{1'b0}}});
    assign idx_ext = CNT_W'(idx_reg);
    assign idx_inc = idx_ext + CNT_W'(1);

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = ovalid_reg;
    assign rsp.frame_index    = oidx_reg;
    assign rsp.current_sprite = ospr_reg;
    assign rsp.sprite_valid   = osv_reg;
    assign rsp.is_playing     = oplay_reg;
    assign rsp.is_finished    = ofin_reg;

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        delta_next    = delta_reg;
        spr_next      = spr_reg;
        dur_next      = dur_reg;
        prod_next     = prod_reg;
        t_next        = t_reg;
        timer_next    = timer_reg;
        idx_next      = idx_reg;
        loaded_next   = loaded_reg;
        playing_next  = playing_reg;
        finished_next = finished_reg;
        run_next      = run_reg;
        ovalid_next   = ovalid_reg;
        oidx_next     = oidx_reg;
        ospr_next     = ospr_reg;
        osv_next      = osv_reg;
        oplay_next    = oplay_reg;
        ofin_next     = ofin_reg;

        tbl_req.we      = 1'b0;
        tbl_req.waddr   = loaded_reg[IDX_W-1:0];
        tbl_req.wsprite = spr_reg;
        tbl_req.wdur    = (dur_reg == '0) ? TIME_W'(1) : dur_reg;
        tbl_req.raddr   = idx_reg;

        if (ovalid_reg && rsp.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.operation;
                    delta_next = req.delta_time;
                    spr_next   = req.new_sprite_id;
                    dur_next   = req.new_duration;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_FETCH;
                case (op_reg)
                    OP_TICK:
                    begin
                        if (playing_reg && loaded_reg != '0)
                        begin
                            prod_next  = PROD_W'(delta_reg) * PROD_W'(play_speed);
                            run_next   = 1'b1;
                            state_next = S_SUM;
                        end
                    end
                    OP_PLAY:
                    begin
                        playing_next  = 1'b1;
                        finished_next = 1'b0;
                    end
                    OP_PAUSE:
                    begin
                        playing_next = 1'b0;
                    end
                    OP_STOP:
                    begin
                        playing_next  = 1'b0;
                        idx_next      = '0;
                        timer_next    = '0;
                        finished_next = 1'b1;
                    end
                    OP_REWIND:
                    begin
                        idx_next      = '0;
                        timer_next    = '0;
                        finished_next = 1'b0;
                    end
                    OP_APPEND:
                    begin
                        if (loaded_reg < CNT_W'(MAX_FRAMES))
                        begin
                            tbl_req.we  = 1'b1;
                            loaded_next = loaded_reg + CNT_W'(1);
                        end
                    end
                    OP_CLEAR:
                    begin
                        loaded_next = '0;
                        idx_next    = '0;
                        timer_next  = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_SUM:
            begin
                // saturate the 1/256-unit timer
                t_next     = sum[TIMER_W] ? '1 : sum[TIMER_W-1:0];
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                // table read of idx_reg lands this edge
                state_next = run_reg ? S_STEP : S_RESP;
            end
            S_STEP:
            begin
                state_next = S_FETCH;
                if (idx_ext >= loaded_reg)
                begin
                    idx_next = '0;
                end
                else if (t_reg >= need)
                begin
                    t_next = t_reg - need;
                    if (idx_inc >= loaded_reg)
                    begin
                        if (loop_enable)
                        begin
                            idx_next = '0;
                        end
                        else
                        begin
                            idx_next      = IDX_W'(loaded_reg - CNT_W'(1));
                            playing_next  = 1'b0;
                            finished_next = 1'b1;
                            timer_next    = t_reg - need;
                            run_next      = 1'b0;
                        end
                    end
                    else
                    begin
                        idx_next = idx_inc[IDX_W-1:0];
                    end
                end
                else
                begin
                    timer_next = t_reg;
                    run_next   = 1'b0;
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next = 1'b1;
                    oidx_next   = idx_reg;
                    ospr_next   = (idx_ext < loaded_reg) ? tbl_rsp.sprite : '0;
                    osv_next    = (loaded_reg != '0);
                    oplay_next  = playing_reg;
                    ofin_next   = finished_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            timer_reg    <= '0;
            idx_reg      <= '0;
            loaded_reg   <= '0;
            playing_reg  <= 1'b0;
            finished_reg <= 1'b0;
            run_reg      <= 1'b0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            timer_reg    <= timer_next;
            idx_reg      <= idx_next;
            loaded_reg   <= loaded_next;
            playing_reg  <= playing_next;
            finished_reg <= finished_next;
            run_reg      <= run_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        delta_reg <= delta_next;
        spr_reg   <= spr_next;
        dur_reg   <= dur_next;
        prod_reg  <= prod_next;
        t_reg     <= t_next;
        oidx_reg  <= oidx_next;
        ospr_reg  <= ospr_next;
        osv_reg   <= osv_next;
        oplay_reg <= oplay_next;
        ofin_reg  <= ofin_next;
    end

endmodule

`default_nettype wire

@@ sv/frame_sequence_player_top.sv @@
// Sprite animation frame sequencer.
// req channel: one item per operation (tick, play, pause, stop, rewind,
//   append frame, clear frames). rsp channel: one item per request with the
//   current frame index, its sprite id and the playing/finished flags.
// cfg port: cfg_we/cfg_index/cfg_data; index 0 loop_enable, 1 play_speed
//   (Q4.8). Write only while no request is in flight.
// Timing: req.ready is high only while the sequencer is idle. A non-tick
//   item, or a tick while stopped or with no frames loaded, passes through
//   the execute, fetch and response states; an active tick adds the sum
//   state after execute. Each frame passed by a tick adds a table read
//   (fetch) and a compare/subtract (step); a tick that ends a non-looping
//   run skips the last compare. req.ready returns together with rsp.valid,
//   so no item is taken before the last one's response is registered.
// The rsp item sits in an output register; the next req item is taken while
//   it waits. If rsp.ready stays low, the following item finishes its work
//   and then holds in the response state until the register frees up.
// Reset: no frames loaded, index and timer zero, stopped, loop on, speed
//   1.0. The frame table itself is not cleared; only loaded entries are read.
`timescale 1ns / 1ps
`default_nettype none

module frame_sequence_player_top import fsp_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    fsp_req_if.sink                    req,
    fsp_rsp_if.source                  rsp,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic             loop_reg;
    logic [SPD_W-1:0] speed_reg;
    tbl_req_t         tbl_req;
    tbl_rsp_t         tbl_rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_reg  <= 1'b1;
            speed_reg <= SPEED_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LOOP:  loop_reg  <= cfg_data[0];
                CFG_SPEED: speed_reg <= cfg_data[SPD_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    fsp_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .loop_enable (loop_reg),
        .play_speed  (speed_reg),
        .req         (req),
        .rsp         (rsp),
        .tbl_req     (tbl_req),
        .tbl_rsp     (tbl_rsp)
    );

    fsp_table u_table (
        .clk (clk),
        .req (tbl_req),
        .rsp (tbl_rsp)
    );

endmodule

`default_nettype wire
